// ===== rtl/rhc_pkg.sv =====
// Package with the types, constants and helper functions of the RGB/HSV colour converter.
`timescale 1ns / 1ps
`default_nettype none
package rhc_pkg;

    localparam int FRAC_BITS            = 15;
    localparam int HUE_STEPS_PER_DEGREE = 64;

    localparam int CH_W      = FRAC_BITS + 1;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = ONE >> 1;
    localparam int SECTOR    = 60 * HUE_STEPS_PER_DEGREE;
    localparam int FULL      = 360 * HUE_STEPS_PER_DEGREE;
    localparam int HALF_TURN = 180 * HUE_STEPS_PER_DEGREE;
    localparam int HUE_W     = $clog2(FULL);
    localparam int REM_W     = $clog2(SECTOR);

    // Numerator widths of the hue and saturation quotients.
    localparam int X_W    = CH_W + 1;
    localparam int HNUM_W = $clog2(SECTOR * 2 * ONE + 1);
    localparam int SNUM_W = CH_W + FRAC_BITS;
    localparam int QUO_W  = CH_W;

    // The sector is an odd factor times a power of two; the odd factor is
    // divided out by a reciprocal multiply followed by one correction step.
    localparam int SECTOR_SHIFT = 8;
    localparam int SECTOR_ODD   = 15;
    localparam int RECIP        = 34952;
    localparam int RECIP_W      = 16;
    localparam int RECIP_SHIFT  = 19;
    localparam int MQ_W         = $clog2(ONE * SECTOR + 1);
    localparam int Y_W          = MQ_W - SECTOR_SHIFT;

    typedef enum logic [1:0] {
        REQ_RGB_TO_HSV = 2'd0,
        REQ_HSV_TO_RGB = 2'd1,
        REQ_INVERT     = 2'd2,
        REQ_BRIGHTEN   = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } hsv_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] in_red;
        logic [15:0] in_green;
        logic [15:0] in_blue;
        logic [15:0] in_hue;
        logic [15:0] in_sat;
        logic [15:0] in_val;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [14:0] out_hue;
        logic [15:0] out_sat;
        logic [15:0] out_val;
    } out_item_t;

    function automatic logic [CH_W-1:0] sat_one(input logic [15:0] x);
        logic [CH_W-1:0] r;
        r = (32'(x) > ONE) ? CH_W'(ONE) : CH_W'(x);
        return r;
    endfunction

    function automatic logic [HUE_W-1:0] hue_wrap(input logic [15:0] x);
        logic [15:0] r;
        if (32'(x) >= 2 * FULL) begin
            r = x - 16'(2 * FULL);
        end else if (32'(x) >= FULL) begin
            r = x - 16'(FULL);
        end else begin
            r = x;
        end
        return HUE_W'(r);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rgb_hsv_color_converter.sv =====
// Top level of the RGB/HSV colour converter: input conditioning, the conversion chain and the output port.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid, req_ready   rhc_pkg::in_item_t
//  rsp      out        rsp_valid, rsp_ready   rhc_pkg::out_item_t
//
// One transaction is accepted per cycle unless the chain is held. The conversion chain is made of three
// RGB-to-HSV sections of 19 stages (two 16-stage dividers each) and two HSV-to-RGB sections
// of 6 stages. Reset clears only the valid bits of every stage.
// When a result waits on rsp, the whole chain holds and req_ready falls; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module rgb_hsv_color_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rhc_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rhc_pkg::out_item_t rsp
);

    typedef struct packed {
        rhc_pkg::req_type_t t;
        rhc_pkg::hsv_t      hsv;
    } ctx0_t;

    typedef struct packed {
        rhc_pkg::req_type_t t;
        logic               dark;
    } ctx1_t;

    logic en;

    rhc_pkg::rgb_t in_rgb;
    ctx0_t         in_ctx;

    logic          a0_valid;
    rhc_pkg::rgb_t a0_rgb;
    rhc_pkg::hsv_t a0_hsv;
    ctx0_t         a0_ctx;

    logic          b1_apply;
    rhc_pkg::hsv_t b1_hsv;
    ctx1_t         b1_ctx_in;

    logic          b1_valid;
    rhc_pkg::rgb_t b1_rgb;
    ctx1_t         b1_ctx;

    logic          a1_valid;
    rhc_pkg::rgb_t a1_rgb;
    rhc_pkg::hsv_t a1_hsv;
    ctx1_t         a1_ctx;

    logic          b2_apply;
    rhc_pkg::hsv_t b2_hsv;

    logic               b2_valid;
    rhc_pkg::rgb_t      b2_rgb;
    rhc_pkg::req_type_t b2_type;

    logic               a2_valid;
    rhc_pkg::rgb_t      a2_rgb;
    rhc_pkg::hsv_t      a2_hsv;
    rhc_pkg::req_type_t a2_type;

    assign en        = !a2_valid || rsp_ready;
    assign req_ready = en;

    always_comb
    begin
        in_rgb.red     = rhc_pkg::sat_one(req.in_red);
        in_rgb.green   = rhc_pkg::sat_one(req.in_green);
        in_rgb.blue    = rhc_pkg::sat_one(req.in_blue);
        in_ctx.t       = req.req_type;
        in_ctx.hsv.hue = rhc_pkg::hue_wrap(req.in_hue);
        in_ctx.hsv.sat = rhc_pkg::sat_one(req.in_sat);
        in_ctx.hsv.val = rhc_pkg::sat_one(req.in_val);
    end

    rhc_rgb2hsv #(.SIDE_W($bits(ctx0_t))) u_a0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_rgb    (in_rgb),
        .in_side   (in_ctx),
        .out_valid (a0_valid),
        .out_rgb   (a0_rgb),
        .out_hsv   (a0_hsv),
        .out_side  (a0_ctx)
    );

    always_comb
    begin
        b1_ctx_in.t    = a0_ctx.t;
        b1_ctx_in.dark = 32'(a0_hsv.val) < rhc_pkg::HALF;
        b1_hsv         = a0_hsv;
        case (a0_ctx.t)
            rhc_pkg::REQ_HSV_TO_RGB:
            begin
                b1_apply = 1'b1;
                b1_hsv   = a0_ctx.hsv;
            end
            rhc_pkg::REQ_INVERT:
            begin
                b1_apply   = 1'b1;
                b1_hsv.hue = rhc_pkg::hue_wrap(16'(a0_hsv.hue) + 16'(rhc_pkg::HALF_TURN));
            end
            rhc_pkg::REQ_BRIGHTEN:
            begin
                b1_apply   = b1_ctx_in.dark;
                b1_hsv.val = rhc_pkg::CH_W'(rhc_pkg::HALF);
            end
            default:
            begin
                b1_apply = 1'b0;
            end
        endcase
    end

    rhc_hsv2rgb #(.SIDE_W($bits(ctx1_t))) u_b1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a0_valid),
        .in_apply  (b1_apply),
        .in_hsv    (b1_hsv),
        .in_rgb    (a0_rgb),
        .in_side   (b1_ctx_in),
        .out_valid (b1_valid),
        .out_rgb   (b1_rgb),
        .out_side  (b1_ctx)
    );

    rhc_rgb2hsv #(.SIDE_W($bits(ctx1_t))) u_a1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b1_valid),
        .in_rgb    (b1_rgb),
        .in_side   (b1_ctx),
        .out_valid (a1_valid),
        .out_rgb   (a1_rgb),
        .out_hsv   (a1_hsv),
        .out_side  (a1_ctx)
    );

    always_comb
    begin
        b2_hsv = a1_hsv;
        case (a1_ctx.t)
            rhc_pkg::REQ_INVERT:
            begin
                b2_apply   = a1_ctx.dark;
                b2_hsv.val = rhc_pkg::CH_W'(rhc_pkg::ONE) - a1_hsv.val;
            end
            rhc_pkg::REQ_BRIGHTEN:
            begin
                b2_apply   = 32'(a1_hsv.sat) < rhc_pkg::HALF;
                b2_hsv.sat = rhc_pkg::CH_W'(rhc_pkg::HALF);
            end
            default:
            begin
                b2_apply = 1'b0;
            end
        endcase
    end

    rhc_hsv2rgb #(.SIDE_W($bits(rhc_pkg::req_type_t))) u_b2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a1_valid),
        .in_apply  (b2_apply),
        .in_hsv    (b2_hsv),
        .in_rgb    (a1_rgb),
        .in_side   (a1_ctx.t),
        .out_valid (b2_valid),
        .out_rgb   (b2_rgb),
        .out_side  (b2_type)
    );

    rhc_rgb2hsv #(.SIDE_W($bits(rhc_pkg::req_type_t))) u_a2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b2_valid),
        .in_rgb    (b2_rgb),
        .in_side   (b2_type),
        .out_valid (a2_valid),
        .out_rgb   (a2_rgb),
        .out_hsv   (a2_hsv),
        .out_side  (a2_type)
    );

    assign rsp_valid     = a2_valid;
    assign rsp.out_red   = a2_rgb.red;
    assign rsp.out_green = a2_rgb.green;
    assign rsp.out_blue  = a2_rgb.blue;
    assign rsp.out_hue   = a2_hsv.hue;
    assign rsp.out_sat   = a2_hsv.sat;
    assign rsp.out_val   = a2_hsv.val;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.out_hue) < rhc_pkg::FULL)
        else $error("Result hue is outside one full turn.");

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.out_sat == '0 |-> rsp.out_hue == '0)
        else $error("Gray result carries a non-zero hue.");

    a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.out_val == '0 |-> rsp.out_sat == '0)
        else $error("Black result carries a non-zero saturation.");

    a_brighten_val: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && a2_type == rhc_pkg::REQ_BRIGHTEN |-> 32'(rsp.out_val) >= rhc_pkg::HALF)
        else $error("Brightened result has a value below one half.");

endmodule
`default_nettype wire

// ===== rtl/rhc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module rhc_div #(
    parameter int NUM_W  = 31,
    parameter int DEN_W  = 16,
    parameter int QUO_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [QUO_W];
    logic [DEN_W-1:0]  rem_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              v_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  low_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [QUO_W-1:0]  low_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = DEN_W'(num >> QUO_W);
            assign den_in  = den;
            assign low_in  = num[QUO_W-1:0];
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial    = {rem_in, low_in[QUO_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        assign low_next = {low_in[QUO_W-2:0], 1'b0};
        assign quo_next = {quo_in[QUO_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                low_reg[k]  <= low_next;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/rhc_rgb2hsv.sv =====
// Pipelined RGB to HSV conversion with two dividers of the same divisor and quotient width.
`timescale 1ns / 1ps
`default_nettype none
module rhc_rgb2hsv #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rhc_pkg::rgb_t     in_rgb,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output rhc_pkg::rgb_t     out_rgb,
    output rhc_pkg::hsv_t     out_hsv,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CH_W  = rhc_pkg::CH_W;
    localparam int HUE_W = rhc_pkg::HUE_W;
    localparam int X_W   = rhc_pkg::X_W;

    typedef struct packed {
        logic [CH_W-1:0]   val;
        rhc_pkg::rgb_t     rgb;
        logic [SIDE_W-1:0] side;
    } s_side_t;

    typedef struct packed {
        logic             d_zero;
        logic [HUE_W-1:0] off;
    } h_side_t;

    logic [CH_W-1:0]  mx, mn, d;
    logic [X_W-1:0]   x;
    logic [HUE_W-1:0] off;

    logic              r0_valid_reg;
    logic [CH_W-1:0]   r0_val_reg, r0_d_reg;
    logic [X_W-1:0]    r0_x_reg;
    logic [HUE_W-1:0]  r0_off_reg;
    rhc_pkg::rgb_t     r0_rgb_reg;
    logic [SIDE_W-1:0] r0_side_reg;

    logic                       r1_valid_reg;
    logic [CH_W-1:0]            r1_val_reg, r1_d_reg;
    logic [rhc_pkg::HNUM_W-1:0] r1_nh_reg;
    logic [HUE_W-1:0]           r1_off_reg;
    rhc_pkg::rgb_t              r1_rgb_reg;
    logic [SIDE_W-1:0]          r1_side_reg;

    s_side_t s_in, s_out;
    h_side_t h_in, h_out;
    logic    s_valid, h_valid;
    logic [rhc_pkg::QUO_W-1:0] quo_s, quo_h;
    logic [CH_W:0]    hue_sum;
    logic [HUE_W-1:0] hue_next;
    logic [CH_W-1:0]  sat_next;

    logic              out_valid_reg;
    rhc_pkg::rgb_t     out_rgb_reg;
    rhc_pkg::hsv_t     out_hsv_reg;
    logic [SIDE_W-1:0] out_side_reg;

    always_comb
    begin
        mx = (in_rgb.red >= in_rgb.green) ? in_rgb.red : in_rgb.green;
        mx = (mx >= in_rgb.blue) ? mx : in_rgb.blue;
        mn = (in_rgb.red <= in_rgb.green) ? in_rgb.red : in_rgb.green;
        mn = (mn <= in_rgb.blue) ? mn : in_rgb.blue;
        d  = mx - mn;
        if (mx == in_rgb.red)
        begin
            x   = X_W'(in_rgb.green) + X_W'(d) - X_W'(in_rgb.blue);
            off = HUE_W'(rhc_pkg::FULL - rhc_pkg::SECTOR);
        end
        else if (mx == in_rgb.green)
        begin
            x   = X_W'(in_rgb.blue) + X_W'(d) - X_W'(in_rgb.red);
            off = HUE_W'(rhc_pkg::SECTOR);
        end
        else
        begin
            x   = X_W'(in_rgb.red) + X_W'(d) - X_W'(in_rgb.green);
            off = HUE_W'(3 * rhc_pkg::SECTOR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_valid_reg <= 1'b0;
            r1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r0_valid_reg <= in_valid;
            r1_valid_reg <= r0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_val_reg  <= mx;
            r0_d_reg    <= d;
            r0_x_reg    <= x;
            r0_off_reg  <= off;
            r0_rgb_reg  <= in_rgb;
            r0_side_reg <= in_side;
            r1_val_reg  <= r0_val_reg;
            r1_d_reg    <= r0_d_reg;
            r1_nh_reg   <= rhc_pkg::HNUM_W'(r0_x_reg * rhc_pkg::SECTOR);
            r1_off_reg  <= r0_off_reg;
            r1_rgb_reg  <= r0_rgb_reg;
            r1_side_reg <= r0_side_reg;
        end
    end

    assign s_in.val  = r1_val_reg;
    assign s_in.rgb  = r1_rgb_reg;
    assign s_in.side = r1_side_reg;
    assign h_in.d_zero = (r1_d_reg == '0);
    assign h_in.off    = r1_off_reg;

    rhc_div #(
        .NUM_W  (rhc_pkg::SNUM_W),
        .DEN_W  (CH_W),
        .QUO_W  (rhc_pkg::QUO_W),
        .SIDE_W ($bits(s_side_t))
    ) u_div_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r1_valid_reg),
        .num       ({r1_d_reg, {rhc_pkg::FRAC_BITS{1'b0}}}),
        .den       (r1_val_reg),
        .in_side   (s_in),
        .out_valid (s_valid),
        .quo       (quo_s),
        .out_side  (s_out)
    );

    rhc_div #(
        .NUM_W  (rhc_pkg::HNUM_W),
        .DEN_W  (CH_W),
        .QUO_W  (rhc_pkg::QUO_W),
        .SIDE_W ($bits(h_side_t))
    ) u_div_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r1_valid_reg),
        .num       (r1_nh_reg),
        .den       (r1_d_reg),
        .in_side   (h_in),
        .out_valid (h_valid),
        .quo       (quo_h),
        .out_side  (h_out)
    );

    always_comb
    begin
        hue_sum = (CH_W + 1)'(quo_h) + (CH_W + 1)'(h_out.off);
        if (32'(hue_sum) >= rhc_pkg::FULL)
        begin
            hue_sum = hue_sum - (CH_W + 1)'(rhc_pkg::FULL);
        end
        hue_next = h_out.d_zero ? '0 : HUE_W'(hue_sum);
        sat_next = (s_out.val == '0) ? '0 : CH_W'(quo_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rgb_reg     <= s_out.rgb;
            out_hsv_reg.hue <= hue_next;
            out_hsv_reg.sat <= sat_next;
            out_hsv_reg.val <= s_out.val;
            out_side_reg    <= s_out.side;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rgb   = out_rgb_reg;
    assign out_hsv   = out_hsv_reg;
    assign out_side  = out_side_reg;

    a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid == h_valid)
        else $error("Saturation and hue divider lanes are out of step.");

endmodule
`default_nettype wire

// ===== rtl/rhc_hsv2rgb.sv =====
// Pipelined HSV to RGB conversion by the six-sector rule, with a bypass for unchanged colours.
`timescale 1ns / 1ps
`default_nettype none
module rhc_hsv2rgb #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic              in_apply,
    input  rhc_pkg::hsv_t     in_hsv,
    input  rhc_pkg::rgb_t     in_rgb,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output rhc_pkg::rgb_t     out_rgb,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CH_W  = rhc_pkg::CH_W;
    localparam int HUE_W = rhc_pkg::HUE_W;
    localparam int REM_W = rhc_pkg::REM_W;
    localparam int MQ_W  = rhc_pkg::MQ_W;
    localparam int Y_W   = rhc_pkg::Y_W;
    localparam int P_W   = Y_W + rhc_pkg::RECIP_W;
    localparam int STAGES = 6;

    typedef struct packed {
        logic              apply;
        logic              gray;
        logic [2:0]        sec;
        logic [CH_W-1:0]   val;
        rhc_pkg::rgb_t     rgb;
        logic [SIDE_W-1:0] side;
    } ctl_t;

    logic valid_reg [STAGES];
    ctl_t ctl_reg   [STAGES-1];

    logic [2:0]       sec;
    logic [HUE_W-1:0] base;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] h0_rem_reg;
    logic [CH_W-1:0]  h0_sat_reg;

    logic [MQ_W-1:0]   h1_mq_reg, h1_mt_reg;
    logic [2*CH_W-1:0] h1_pa_reg;

    logic [Y_W-1:0]  h2_yq_reg, h2_yt_reg;
    logic [P_W-1:0]  h2_pq_reg, h2_pt_reg;
    logic [CH_W-1:0] h2_p_reg;

    logic [CH_W-1:0] q0, t0, quo_q, quo_t;
    logic [Y_W-1:0]  rq, rt;
    logic [CH_W-1:0] h3_fq_reg, h3_ft_reg, h3_p_reg;

    logic [2*CH_W-1:0] h4_mq_reg, h4_mt_reg;
    logic [CH_W-1:0]   h4_p_reg;

    logic [CH_W-1:0] q, t, p, v;
    rhc_pkg::rgb_t   rgb_next;
    rhc_pkg::rgb_t   out_rgb_reg;
    logic [SIDE_W-1:0] out_side_reg;

    always_comb
    begin
        if (32'(in_hsv.hue) >= 5 * rhc_pkg::SECTOR)
        begin
            sec  = 3'd5;
            base = HUE_W'(5 * rhc_pkg::SECTOR);
        end
        else if (32'(in_hsv.hue) >= 4 * rhc_pkg::SECTOR)
        begin
            sec  = 3'd4;
            base = HUE_W'(4 * rhc_pkg::SECTOR);
        end
        else if (32'(in_hsv.hue) >= 3 * rhc_pkg::SECTOR)
        begin
            sec  = 3'd3;
            base = HUE_W'(3 * rhc_pkg::SECTOR);
        end
        else if (32'(in_hsv.hue) >= 2 * rhc_pkg::SECTOR)
        begin
            sec  = 3'd2;
            base = HUE_W'(2 * rhc_pkg::SECTOR);
        end
        else if (32'(in_hsv.hue) >= rhc_pkg::SECTOR)
        begin
            sec  = 3'd1;
            base = HUE_W'(rhc_pkg::SECTOR);
        end
        else
        begin
            sec  = 3'd0;
            base = '0;
        end
        rem = REM_W'(in_hsv.hue - base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_comb
    begin
        q0    = CH_W'(h2_pq_reg >> rhc_pkg::RECIP_SHIFT);
        t0    = CH_W'(h2_pt_reg >> rhc_pkg::RECIP_SHIFT);
        rq    = h2_yq_reg - Y_W'(q0 * rhc_pkg::SECTOR_ODD);
        rt    = h2_yt_reg - Y_W'(t0 * rhc_pkg::SECTOR_ODD);
        quo_q = (32'(rq) >= rhc_pkg::SECTOR_ODD) ? q0 + 1'b1 : q0;
        quo_t = (32'(rt) >= rhc_pkg::SECTOR_ODD) ? t0 + 1'b1 : t0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0].apply <= in_apply;
            ctl_reg[0].gray  <= (in_hsv.sat == '0);
            ctl_reg[0].sec   <= sec;
            ctl_reg[0].val   <= in_hsv.val;
            ctl_reg[0].rgb   <= in_rgb;
            ctl_reg[0].side  <= in_side;
            for (int k = 1; k < STAGES - 1; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            h0_rem_reg <= rem;
            h0_sat_reg <= in_hsv.sat;

            h1_mq_reg <= MQ_W'(h0_sat_reg * h0_rem_reg);
            h1_mt_reg <= MQ_W'(h0_sat_reg * (REM_W + 1)'(rhc_pkg::SECTOR - h0_rem_reg));
            h1_pa_reg <= ctl_reg[0].val * (CH_W'(rhc_pkg::ONE) - h0_sat_reg);

            h2_yq_reg <= Y_W'(h1_mq_reg >> rhc_pkg::SECTOR_SHIFT);
            h2_yt_reg <= Y_W'(h1_mt_reg >> rhc_pkg::SECTOR_SHIFT);
            h2_pq_reg <= P_W'((h1_mq_reg >> rhc_pkg::SECTOR_SHIFT)
                              * rhc_pkg::RECIP_W'(rhc_pkg::RECIP));
            h2_pt_reg <= P_W'((h1_mt_reg >> rhc_pkg::SECTOR_SHIFT)
                              * rhc_pkg::RECIP_W'(rhc_pkg::RECIP));
            h2_p_reg  <= CH_W'(h1_pa_reg >> rhc_pkg::FRAC_BITS);

            h3_fq_reg <= CH_W'(rhc_pkg::ONE) - quo_q;
            h3_ft_reg <= CH_W'(rhc_pkg::ONE) - quo_t;
            h3_p_reg  <= h2_p_reg;

            h4_mq_reg <= ctl_reg[3].val * h3_fq_reg;
            h4_mt_reg <= ctl_reg[3].val * h3_ft_reg;
            h4_p_reg  <= h3_p_reg;

            out_rgb_reg  <= rgb_next;
            out_side_reg <= ctl_reg[4].side;
        end
    end

    always_comb
    begin
        q = CH_W'(h4_mq_reg >> rhc_pkg::FRAC_BITS);
        t = CH_W'(h4_mt_reg >> rhc_pkg::FRAC_BITS);
        p = h4_p_reg;
        v = ctl_reg[4].val;
        case (ctl_reg[4].sec)
            3'd0:    rgb_next = '{red: v, green: t, blue: p};
            3'd1:    rgb_next = '{red: q, green: v, blue: p};
            3'd2:    rgb_next = '{red: p, green: v, blue: t};
            3'd3:    rgb_next = '{red: p, green: q, blue: v};
            3'd4:    rgb_next = '{red: t, green: p, blue: v};
            default: rgb_next = '{red: v, green: p, blue: q};
        endcase
        if (ctl_reg[4].gray)
        begin
            rgb_next = '{red: v, green: v, blue: v};
        end
        if (!ctl_reg[4].apply)
        begin
            rgb_next = ctl_reg[4].rgb;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_rgb   = out_rgb_reg;
    assign out_side  = out_side_reg;

endmodule
`default_nettype wire
